// File: rtl/lock_order_cycle_checker_core_macros.svh
// ----------------------------------------------------------------------------
// lock order cycle checker assertion macros
// shared helpers for concurrent checks, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef LOCK_ORDER_CYCLE_CHECKER_CORE_MACROS_SVH
`define LOCK_ORDER_CYCLE_CHECKER_CORE_MACROS_SVH

// same-cycle implication
`define LOCC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("locc check failed");

// next-cycle implication
`define LOCC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("locc check failed");

`endif

// File: rtl/locc_pkg.sv
// ----------------------------------------------------------------------------
// locc_pkg
// shared constants, status codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package locc_pkg;

  localparam int LOCKS       = 64;
  localparam int STACK_DEPTH = 16;
  localparam int LOCK_W      = 6;
  localparam int SCAN_W      = LOCK_W + 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int HIDX_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STAT_W      = 3;

  localparam logic CMD_ACQUIRE = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_TOP  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DEADLOCK = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STAT_W-1:0] ST_HALTED   = 3'd5;

  typedef struct packed {
    logic latch;        // capture request
    logic rd_top;       // graph read port on held-stack top
    logic check;        // classify request, edge insert, push or pop
    logic root_next;    // advance search root
    logic root_visit;   // start tree at current root
    logic scan_next;    // advance scan column
    logic descend;      // save here, move to unvisited neighbor
    logic finish_here;  // mark current node finished
    logic pop_node;     // resume parent from search stack
    logic set_deadlock; // record back edge
    logic push_held;    // search clean, push lock
    logic load_out;     // move result into output register
  } cmd_t;

  typedef struct packed {
    logic need_search;
    logic root_end;
    logic root_visited;
    logic scan_end;
    logic bit_set;
    logic there_visited;
    logic there_finished;
    logic depth_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/locc_ctrl.sv
// ----------------------------------------------------------------------------
// locc_ctrl
// sequencer for request check and depth-first cycle search
// ----------------------------------------------------------------------------
`default_nettype none

module locc_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_fire,
  output logic                 in_ready,
  input  wire locc_pkg::sts_t  sts,
  output locc_pkg::cmd_t       cmd
);
  import locc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_ROOT  = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.rd_top = 1'b1;
        if (in_fire) begin
          cmd.latch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.need_search ? S_ROOT : S_DONE;
      end
      S_ROOT: begin
        if (sts.root_end) begin
          cmd.push_held = 1'b1;
          state_nxt     = S_DONE;
        end else if (sts.root_visited) begin
          cmd.root_next = 1'b1;
        end else begin
          cmd.root_visit = 1'b1;
          state_nxt      = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.scan_end) begin
          cmd.finish_here = 1'b1;
          if (sts.depth_zero) begin
            cmd.root_next = 1'b1;
            state_nxt     = S_ROOT;
          end else begin
            cmd.pop_node = 1'b1;
            state_nxt    = S_LOAD;
          end
        end else if (sts.bit_set && !sts.there_visited) begin
          cmd.descend = 1'b1;
          state_nxt   = S_LOAD;
        end else if (sts.bit_set && !sts.there_finished) begin
          cmd.set_deadlock = 1'b1;
          state_nxt        = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/locc_dp.sv
// ----------------------------------------------------------------------------
// locc_dp
// held stack, order graph memory, search marks and stack, result registers
// ----------------------------------------------------------------------------
`default_nettype none

`include "lock_order_cycle_checker_core_macros.svh"

module locc_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_command,
  input  wire [locc_pkg::LOCK_W-1:0]         in_lock_id,
  input  wire locc_pkg::cmd_t                cmd,
  output locc_pkg::sts_t                     sts,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic [locc_pkg::STAT_W-1:0]        out_status,
  output logic [locc_pkg::LOCK_W-1:0]        out_from,
  output logic [locc_pkg::LOCK_W-1:0]        out_to
);
  import locc_pkg::*;

  localparam int ENT_W = LOCK_W + SCAN_W;

  // request
  logic              cmd_r;
  logic [LOCK_W-1:0] id_r;

  // held stack
  logic [LOCK_W-1:0] held_r [STACK_DEPTH];
  logic [CNT_W-1:0]  held_cnt_r;
  logic [CNT_W-1:0]  top_pos;
  logic [LOCK_W-1:0] top_id;
  logic              halted_r;

  // order graph
  logic [LOCKS-1:0]  graph_mem [LOCKS];
  logic [LOCKS-1:0]  row_valid_r;
  logic [LOCKS-1:0]  rd_q;
  logic              rvld_q;
  logic [LOCKS-1:0]  row;
  logic [LOCK_W-1:0] raddr;

  // search
  logic [LOCKS-1:0]  visited_r, finished_r;
  logic [SCAN_W-1:0] root_r;
  logic [LOCK_W-1:0] here_r;
  logic [SCAN_W-1:0] scan_r;
  logic [LOCK_W-1:0] depth_r;
  logic [ENT_W-1:0]  stk_mem [LOCKS];
  logic [ENT_W-1:0]  stk_q;
  logic [LOCK_W-1:0] there;
  logic [LOCK_W-1:0] depth_m1;

  // result
  logic [STAT_W-1:0] res_status_r;
  logic [LOCK_W-1:0] res_from_r, res_to_r;
  logic [STAT_W-1:0] chk_status;
  logic              need_search;

  assign top_pos  = held_cnt_r - CNT_W'(1);
  assign top_id   = held_r[top_pos[HIDX_W-1:0]];
  assign raddr    = cmd.rd_top ? top_id : here_r;
  assign row      = rvld_q ? rd_q : '0;
  assign there    = scan_r[LOCK_W-1:0];
  assign depth_m1 = depth_r - LOCK_W'(1);

  always_comb begin
    chk_status = ST_OK;
    if (halted_r) begin
      chk_status = ST_HALTED;
    end else if (cmd_r == CMD_RELEASE) begin
      if (held_cnt_r == '0) chk_status = ST_EMPTY;
      else if (top_id != id_r) chk_status = ST_NOT_TOP;
    end else if (held_cnt_r == CNT_W'(STACK_DEPTH)) begin
      chk_status = ST_FULL;
    end
  end

  assign need_search = (chk_status == ST_OK) && (cmd_r == CMD_ACQUIRE) &&
                       (held_cnt_r != '0) && (top_id != id_r) && !row[id_r];

  assign sts.need_search    = need_search;
  assign sts.root_end       = (root_r == SCAN_W'(LOCKS));
  assign sts.root_visited   = visited_r[root_r[LOCK_W-1:0]];
  assign sts.scan_end       = (scan_r == SCAN_W'(LOCKS));
  assign sts.bit_set        = row[there];
  assign sts.there_visited  = visited_r[there];
  assign sts.there_finished = finished_r[there];
  assign sts.depth_zero     = (depth_r == '0);
  assign sts.out_free       = !out_valid || out_ready;

  // graph memory, registered read
  always_ff @(posedge clk) begin
    rd_q   <= graph_mem[raddr];
    rvld_q <= row_valid_r[raddr];
    if (cmd.check && need_search) begin
      graph_mem[top_id] <= row | (LOCKS'(1) << id_r);
    end
  end

  // search stack memory, registered read at depth-1
  always_ff @(posedge clk) begin
    stk_q <= stk_mem[depth_m1];
    if (cmd.descend) begin
      stk_mem[depth_r] <= {here_r, scan_r + SCAN_W'(1)};
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_command;
      id_r  <= in_lock_id;
    end
    if ((cmd.check && chk_status == ST_OK && cmd_r == CMD_ACQUIRE && !need_search) ||
        cmd.push_held) begin
      held_r[held_cnt_r[HIDX_W-1:0]] <= id_r;
    end
    if (cmd.check) begin
      res_status_r <= chk_status;
      res_from_r   <= '0;
      res_to_r     <= '0;
      root_r       <= '0;
    end
    if (cmd.root_next) root_r <= root_r + SCAN_W'(1);
    if (cmd.root_visit) begin
      here_r  <= root_r[LOCK_W-1:0];
      scan_r  <= '0;
      depth_r <= '0;
    end
    if (cmd.scan_next) scan_r <= scan_r + SCAN_W'(1);
    if (cmd.descend) begin
      here_r  <= there;
      scan_r  <= '0;
      depth_r <= depth_r + LOCK_W'(1);
    end
    if (cmd.pop_node) begin
      here_r  <= stk_q[ENT_W-1:SCAN_W];
      scan_r  <= stk_q[SCAN_W-1:0];
      depth_r <= depth_m1;
    end
    if (cmd.set_deadlock) begin
      res_status_r <= ST_DEADLOCK;
      res_from_r   <= here_r;
      res_to_r     <= there;
    end
    if (cmd.load_out) begin
      out_status <= res_status_r;
      out_from   <= res_from_r;
      out_to     <= res_to_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r  <= '0;
      halted_r    <= 1'b0;
      row_valid_r <= '0;
      visited_r   <= '0;
      finished_r  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.check && chk_status == ST_OK) begin
        if (cmd_r == CMD_RELEASE) held_cnt_r <= held_cnt_r - CNT_W'(1);
        else if (!need_search) held_cnt_r <= held_cnt_r + CNT_W'(1);
      end
      if (cmd.push_held) held_cnt_r <= held_cnt_r + CNT_W'(1);
      if (cmd.check && need_search) begin
        row_valid_r[top_id] <= 1'b1;
        visited_r           <= '0;
        finished_r          <= '0;
      end
      if (cmd.root_visit) visited_r[root_r[LOCK_W-1:0]] <= 1'b1;
      if (cmd.descend) visited_r[there] <= 1'b1;
      if (cmd.finish_here) finished_r[here_r] <= 1'b1;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
        if (res_status_r != ST_OK && res_status_r != ST_HALTED) halted_r <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LOCC_ASSERT_IMP(a_finished_visited, 1'b1, ((finished_r & ~visited_r) == '0))
  `LOCC_ASSERT_IMP(a_held_bound, 1'b1, (held_cnt_r <= CNT_W'(STACK_DEPTH)))
  `LOCC_ASSERT_NXT(a_error_halts, cmd.load_out && res_status_r != ST_OK && res_status_r != ST_HALTED, halted_r)
  `LOCC_ASSERT_IMP(a_deadlock_on_stack, cmd.set_deadlock, visited_r[there] && !finished_r[there])

endmodule

`default_nettype wire

// File: rtl/lock_order_cycle_checker_core.sv
// ----------------------------------------------------------------------------
// lock_order_cycle_checker_core
// lock acquire/release tracker with lock-order graph and deadlock search
// ----------------------------------------------------------------------------
// usage
//   input stream: one request per lock event, in_tuser is the command
//   (acquire or release) and in_tdata carries the lock id
//   output stream: exactly one result per request, out_tuser is the status
//   code, out_tdata the back edge (from, to) when a deadlock is reported
//   a request that adds no new edge is latched, checked and moved into the
//   output register; a new edge starts a depth-first search that walks the
//   adjacency rows one bit per cycle until a back edge is found or every
//   search root is done
//   throughput: one request at a time; the single-port graph memory and the
//   bit-serial row scan set the search time
//   reset: synchronous rst_n clears the graph (per-row valid bits), the held
//   stack count, the halt flag and the output register; no clearing pass
//   stall: a result waits in the output register while out_tready is low,
//   the block holds at its final step and takes no new request until then
//   errors halt the block: every later request returns the halted status
// ----------------------------------------------------------------------------
`default_nettype none

module lock_order_cycle_checker_core (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [5:0] lock_id, [7:6] zero
  input  wire         in_tuser,   // [0] command
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [5:0] cycle_from, [11:6] cycle_to, [15:12] zero
  output logic [2:0]  out_tuser   // [2:0] status
);
  import locc_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic              in_fire;
  logic [LOCK_W-1:0] out_from, out_to;

  // request handshake
  assign in_fire = in_tvalid && in_tready;

  // sequencer
  locc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and search datapath
  locc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_command (in_tuser),
    .in_lock_id (in_tdata[LOCK_W-1:0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_status (out_tuser),
    .out_from   (out_from),
    .out_to     (out_to)
  );

  // pack result, zero fill to whole bytes
  assign out_tdata = {4'b0000, out_to, out_from};

endmodule

`default_nettype wire
